// ===== design/atp_pkg.sv =====
// shared constants, coefficient table and types for the atan2 polynomial core
package atp_pkg;

    // defaults for the top level parameters
    localparam int COORD_WIDTH_DEF = 16;
    localparam int ANGLE_FRAC_DEF  = 13;

    // ratio min/max in q1.16, one integer bit so that 1.0 fits
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_W    = RATIO_FRAC + 1;

    // the divider yields floor(min * 2^17 / max), one bit per cell
    localparam int QUO_W     = RATIO_FRAC + 2;
    localparam int DIV_STEPS = QUO_W;

    // horner accumulator in signed q1.30
    localparam int ACC_W     = 32;
    localparam int NUM_COEF  = 7;
    localparam int RND_SHIFT = 16;
    localparam int PROD_W    = ACC_W + RATIO_W + 1;
    localparam int RND_W     = PROD_W - RND_SHIFT;

    // angle before the output rounding, signed q2.30 with headroom
    localparam int ANG_W = 34;
    localparam int MAG_A_W = 32;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] PI_Q30      = 34'sd3373259426;

    // odd minimax polynomial, highest power first
    localparam logic signed [ACC_W-1:0] POLY_COEF [0:NUM_COEF-1] = '{
        32'sd7744777,
        -32'sd37645046,
        32'sd87698811,
        -32'sd143609290,
        32'sd213208227,
        -32'sd357824448,
        32'sd1073741824
    };

    // per word side information carried down the chain
    typedef struct packed {
        logic zero;
        logic y_bigger;
        logic x_neg;
        logic y_neg;
    } flags_t;

endpackage

// ===== design/atan2_polynomial_core.sv =====
// top level of the pipelined four-quadrant atan2 core
//
// input channel: coord_valid / coord_stall carry one word of x_coord and
// y_coord; a word is taken at a rising edge with coord_valid high and
// coord_stall low
// output channel: angle_valid / angle_stall carry atan2(y, x) in radians
// scaled by 2^ANGLE_FRAC_BITS; a word leaves when angle_valid is high and
// angle_stall is low
// throughput: one word per clock while the skid register is empty, set by the
// chain of division cells and horner cells, each of which hands its word to the
// next cell every cycle that the chain is not frozen; a word passes 30
// registers (1 operand stage, 18 division cells, ratio and square stages, 7
// horner cells, 1 reflect stage, 1 output register), the first loaded at the
// accepting edge
// reset clears every valid bit; the chain comes up empty and ready
// when the receiver stalls, the output register holds its word and one more
// word may land in the skid register; while that is full the whole chain
// freezes and coord_stall is high, so no word is ever dropped
module atan2_polynomial_core #(
    parameter int COORD_WIDTH     = atp_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = atp_pkg::ANGLE_FRAC_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               coord_valid,
    output logic                               coord_stall,
    input  logic signed [COORD_WIDTH-1:0]      x_coord,
    input  logic signed [COORD_WIDTH-1:0]      y_coord,
    output logic                               angle_valid,
    input  logic                               angle_stall,
    output logic signed [ANGLE_FRAC_BITS+2:0]  angle
);
    import atp_pkg::*;

    localparam int ANGLE_W = ANGLE_FRAC_BITS + 3;
    localparam int OUT_SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int RND_POS = 29 - ANGLE_FRAC_BITS;

    // chain advances whenever the skid register is free
    logic en;

    // operand stage
    logic [COORD_WIDTH-1:0]  ax;
    logic [COORD_WIDTH-1:0]  ay;
    flags_t                  flags_next;
    logic [COORD_WIDTH-1:0]  big_next;
    logic [COORD_WIDTH-1:0]  small_next;
    logic                    op_valid_reg;
    flags_t                  op_flags_reg;
    logic [COORD_WIDTH-1:0]  op_big_reg;
    logic [COORD_WIDTH-1:0]  op_small_reg;

    // division chain
    logic                    dv_valid [0:DIV_STEPS];
    flags_t                  dv_flags [0:DIV_STEPS];
    logic [COORD_WIDTH-1:0]  dv_big   [0:DIV_STEPS];
    logic [COORD_WIDTH:0]    dv_rem   [0:DIV_STEPS];
    logic [QUO_W-1:0]        dv_quo   [0:DIV_STEPS];

    // ratio and square stages
    logic [QUO_W:0]          q_plus;
    logic [RATIO_W-1:0]      r_next;
    logic                    rt_valid_reg;
    flags_t                  rt_flags_reg;
    logic [RATIO_W-1:0]      rt_r_reg;
    logic [2*RATIO_W-1:0]    r_sq;
    logic [2*RATIO_W-1:0]    r_sq_rnd;
    logic [RATIO_W-1:0]      s_next;
    logic                    sq_valid_reg;
    flags_t                  sq_flags_reg;
    logic [RATIO_W-1:0]      sq_r_reg;
    logic [RATIO_W-1:0]      sq_s_reg;

    // horner chain
    logic                    hc_valid [0:NUM_COEF];
    flags_t                  hc_flags [0:NUM_COEF];
    logic signed [ACC_W-1:0] hc_acc   [0:NUM_COEF];
    logic [RATIO_W-1:0]      hc_s     [0:NUM_COEF];
    logic [RATIO_W-1:0]      hc_r     [0:NUM_COEF];

    // reflect stage
    logic signed [ANG_W-1:0] t_ext;
    logic signed [ANG_W-1:0] a_oct;
    logic signed [ANG_W-1:0] a_half;
    logic [MAG_A_W-1:0]      a_next;
    logic                    rf_valid_reg;
    flags_t                  rf_flags_reg;
    logic [MAG_A_W-1:0]      rf_a_reg;

    // output rounding, output register and skid register
    logic [MAG_A_W:0]        a_rnd;
    logic [ANGLE_W-1:0]      mag;
    logic [ANGLE_W-1:0]      angle_calc;
    logic                    out_free;
    logic                    angle_valid_reg;
    logic                    angle_valid_next;
    logic [ANGLE_W-1:0]      angle_reg;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic [ANGLE_W-1:0]      skid_angle_reg;
    logic                    load_out;
    logic                    load_out_skid;
    logic                    load_skid;

    assign en          = !skid_valid_reg;
    assign coord_stall = skid_valid_reg;

    // magnitudes, larger/smaller pick and quadrant flags
    always_comb
    begin
        ax = x_coord[COORD_WIDTH-1] ? (~x_coord + 1'b1) : x_coord;
        ay = y_coord[COORD_WIDTH-1] ? (~y_coord + 1'b1) : y_coord;
        flags_next.y_bigger = (ay > ax);
        flags_next.x_neg    = x_coord[COORD_WIDTH-1];
        flags_next.y_neg    = y_coord[COORD_WIDTH-1];
        big_next   = flags_next.y_bigger ? ay : ax;
        small_next = flags_next.y_bigger ? ax : ay;
        flags_next.zero = (big_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_valid_reg <= 1'b0;
            rt_valid_reg <= 1'b0;
            sq_valid_reg <= 1'b0;
            rf_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            op_valid_reg <= coord_valid;
            rt_valid_reg <= dv_valid[DIV_STEPS];
            sq_valid_reg <= rt_valid_reg;
            rf_valid_reg <= hc_valid[NUM_COEF];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            op_flags_reg <= flags_next;
            op_big_reg   <= big_next;
            op_small_reg <= small_next;
            rt_flags_reg <= dv_flags[DIV_STEPS];
            rt_r_reg     <= r_next;
            sq_flags_reg <= rt_flags_reg;
            sq_r_reg     <= rt_r_reg;
            sq_s_reg     <= s_next;
            rf_flags_reg <= hc_flags[NUM_COEF];
            rf_a_reg     <= a_next;
        end
    end

    // division chain: floor(small * 2^17 / big), msb first
    assign dv_valid[0] = op_valid_reg;
    assign dv_flags[0] = op_flags_reg;
    assign dv_big[0]   = op_big_reg;
    assign dv_rem[0]   = {1'b0, op_small_reg};
    assign dv_quo[0]   = '0;

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        atp_div_cell #(
            .MAG_W (COORD_WIDTH)
        ) u_div_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (dv_valid[i]),
            .flags_in  (dv_flags[i]),
            .big_in    (dv_big[i]),
            .rem_in    (dv_rem[i]),
            .quo_in    (dv_quo[i]),
            .valid_out (dv_valid[i+1]),
            .flags_out (dv_flags[i+1]),
            .big_out   (dv_big[i+1]),
            .rem_out   (dv_rem[i+1]),
            .quo_out   (dv_quo[i+1])
        );
    end

    // halving with round-up gives the q1.16 ratio rounded to nearest
    always_comb
    begin
        q_plus   = {1'b0, dv_quo[DIV_STEPS]} + (QUO_W+1)'(1);
        r_next   = q_plus[RATIO_W:1];
        r_sq     = rt_r_reg * rt_r_reg;
        r_sq_rnd = r_sq + (2*RATIO_W)'(32768);
        s_next   = r_sq_rnd[RATIO_FRAC+RATIO_W-1:RATIO_FRAC];
    end

    // horner chain: six steps on s, the last cell multiplies by r
    assign hc_valid[0] = sq_valid_reg;
    assign hc_flags[0] = sq_flags_reg;
    assign hc_acc[0]   = POLY_COEF[0];
    assign hc_s[0]     = sq_s_reg;
    assign hc_r[0]     = sq_r_reg;

    for (genvar k = 0; k < NUM_COEF; k++)
    begin : g_horner
        logic [RATIO_W-1:0]      mul_sel;
        logic signed [ACC_W-1:0] coef_sel;

        if (k < NUM_COEF - 1)
        begin : g_even
            assign mul_sel  = hc_s[k];
            assign coef_sel = POLY_COEF[k+1];
        end
        else
        begin : g_odd
            assign mul_sel  = hc_r[k];
            assign coef_sel = '0;
        end

        atp_horner_cell u_horner_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .valid_in  (hc_valid[k]),
            .flags_in  (hc_flags[k]),
            .acc_in    (hc_acc[k]),
            .s_in      (hc_s[k]),
            .r_in      (hc_r[k]),
            .mul_in    (mul_sel),
            .coef      (coef_sel),
            .valid_out (hc_valid[k+1]),
            .flags_out (hc_flags[k+1]),
            .acc_out   (hc_acc[k+1]),
            .s_out     (hc_s[k+1]),
            .r_out     (hc_r[k+1])
        );
    end

    // octant angle to the range 0 to pi, clamped at zero
    always_comb
    begin
        t_ext  = {{(ANG_W-ACC_W){hc_acc[NUM_COEF][ACC_W-1]}}, hc_acc[NUM_COEF]};
        a_oct  = hc_flags[NUM_COEF].y_bigger ? (HALF_PI_Q30 - t_ext) : t_ext;
        a_half = hc_flags[NUM_COEF].x_neg ? (PI_Q30 - a_oct) : a_oct;
        a_next = a_half[ANG_W-1] ? '0 : a_half[MAG_A_W-1:0];
    end

    // round to the output scale, apply the sign of y, origin gives zero
    always_comb
    begin
        a_rnd = {1'b0, rf_a_reg} + ((MAG_A_W+1)'(1) << RND_POS);
        mag   = a_rnd[MAG_A_W:OUT_SHIFT];
        if (rf_flags_reg.zero)
        begin
            angle_calc = '0;
        end
        else if (rf_flags_reg.y_neg)
        begin
            angle_calc = ~mag + 1'b1;
        end
        else
        begin
            angle_calc = mag;
        end
    end

    // output register with one skid word behind it
    always_comb
    begin
        out_free         = !angle_valid_reg || !angle_stall;
        load_out_skid    = skid_valid_reg && out_free;
        load_out         = !skid_valid_reg && out_free;
        load_skid        = !skid_valid_reg && !out_free && rf_valid_reg;
        angle_valid_next = angle_valid_reg;
        skid_valid_next  = skid_valid_reg;
        if (load_out_skid)
        begin
            angle_valid_next = 1'b1;
            skid_valid_next  = 1'b0;
        end
        else if (load_out)
        begin
            angle_valid_next = rf_valid_reg;
        end
        else if (load_skid)
        begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_valid_reg <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            angle_valid_reg <= angle_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_skid)
        begin
            angle_reg <= skid_angle_reg;
        end
        else if (load_out)
        begin
            angle_reg <= angle_calc;
        end
        if (load_skid)
        begin
            skid_angle_reg <= angle_calc;
        end
    end

    assign angle_valid = angle_valid_reg;
    assign angle       = angle_reg;

endmodule

// ===== design/atp_div_cell.sv =====
// one restoring division cell: yields one quotient bit per word and passes on
module atp_div_cell #(
    parameter int MAG_W = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  atp_pkg::flags_t            flags_in,
    input  logic [MAG_W-1:0]           big_in,
    input  logic [MAG_W:0]             rem_in,
    input  logic [atp_pkg::QUO_W-1:0]  quo_in,
    output logic                       valid_out,
    output atp_pkg::flags_t            flags_out,
    output logic [MAG_W-1:0]           big_out,
    output logic [MAG_W:0]             rem_out,
    output logic [atp_pkg::QUO_W-1:0]  quo_out
);
    import atp_pkg::*;

    logic               ge;
    logic [MAG_W:0]     diff;
    logic [MAG_W:0]     rem_next;
    logic [QUO_W-1:0]   quo_next;

    logic               valid_reg;
    flags_t             flags_reg;
    logic [MAG_W-1:0]   big_reg;
    logic [MAG_W:0]     rem_reg;
    logic [QUO_W-1:0]   quo_reg;

    // remainder stays below the divisor after the subtract, so doubling fits
    always_comb
    begin
        ge       = (rem_in >= {1'b0, big_in});
        diff     = rem_in - (ge ? {1'b0, big_in} : {(MAG_W+1){1'b0}});
        rem_next = {diff[MAG_W-1:0], 1'b0};
        quo_next = {quo_in[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= flags_in;
            big_reg   <= big_in;
            rem_reg   <= rem_next;
            quo_reg   <= quo_next;
        end
    end

    assign valid_out = valid_reg;
    assign flags_out = flags_reg;
    assign big_out   = big_reg;
    assign rem_out   = rem_reg;
    assign quo_out   = quo_reg;

endmodule

// ===== design/atp_horner_cell.sv =====
// one horner cell: acc * multiplicand, rounded to q1.30, plus coefficient
module atp_horner_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               valid_in,
    input  atp_pkg::flags_t                    flags_in,
    input  logic signed [atp_pkg::ACC_W-1:0]   acc_in,
    input  logic [atp_pkg::RATIO_W-1:0]        s_in,
    input  logic [atp_pkg::RATIO_W-1:0]        r_in,
    input  logic [atp_pkg::RATIO_W-1:0]        mul_in,
    input  logic signed [atp_pkg::ACC_W-1:0]   coef,
    output logic                               valid_out,
    output atp_pkg::flags_t                    flags_out,
    output logic signed [atp_pkg::ACC_W-1:0]   acc_out,
    output logic [atp_pkg::RATIO_W-1:0]        s_out,
    output logic [atp_pkg::RATIO_W-1:0]        r_out
);
    import atp_pkg::*;

    logic signed [RATIO_W:0]   mul_s;
    logic signed [PROD_W-1:0]  prod;
    logic signed [PROD_W-1:0]  prod_rnd;
    logic signed [RND_W-1:0]   rnd;
    logic signed [RND_W-1:0]   sum;
    logic signed [ACC_W-1:0]   acc_next;

    logic                      valid_reg;
    flags_t                    flags_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [RATIO_W-1:0]        s_reg;
    logic [RATIO_W-1:0]        r_reg;

    // round half up by adding half an lsb then an arithmetic shift
    always_comb
    begin
        mul_s    = $signed({1'b0, mul_in});
        prod     = acc_in * mul_s;
        prod_rnd = prod + PROD_W'(32'sd32768);
        rnd      = prod_rnd[PROD_W-1:RND_SHIFT];
        sum      = rnd + {{(RND_W-ACC_W){coef[ACC_W-1]}}, coef};
        acc_next = sum[ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg <= flags_in;
            acc_reg   <= acc_next;
            s_reg     <= s_in;
            r_reg     <= r_in;
        end
    end

    assign valid_out = valid_reg;
    assign flags_out = flags_reg;
    assign acc_out   = acc_reg;
    assign s_out     = s_reg;
    assign r_out     = r_reg;

endmodule
